@@ rtl/core/base64_stream_decoder_unit_assert.svh @@
// Assertion macros for the base64 stream decoder.
// B64D_ASSERT checks a property on the rising clock edge, off while reset is held.
// B64D_ASSERT_RST checks a property on the rising clock edge, also during reset.
`ifndef BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define B64D_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

`define B64D_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define B64D_ASSERT(label, clk, rst_n, prop)

`define B64D_ASSERT_RST(label, clk, prop)

`endif

`endif

@@ rtl/core/b64d_pkg.sv @@
package b64d_pkg;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 16;
    localparam int LEN_W   = 16;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // configuration register indexes
    localparam logic [1:0] CFG_URL_ALPHABET = 2'd0;
    localparam logic [1:0] CFG_PAD_REQUIRED = 2'd1;
    localparam logic [1:0] CFG_TRAIL_CHECK  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FORMAT   = 2'd1;
    localparam logic [1:0] ST_TRAILING = 2'd2;

    typedef enum logic [1:0] {
        PH_COLLECT = 2'd0,
        PH_PAD     = 2'd1,
        PH_AFTER   = 2'd2,
        PH_DECIDED = 2'd3
    } phase_t;

    typedef struct packed {
        logic url_alphabet;
        logic pad_required;
        logic trail_check;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [17:0] sextets;
        logic [1:0] bcount;
        logic [1:0] pads_left;
        logic [1:0] fstatus;
    } run_state_t;

    // all results caused by one item: up to three bytes, then maybe a status
    typedef struct packed {
        logic [1:0]              nbytes;
        logic [2:0][BYTE_W-1:0]  bytes;
        logic                    has_status;
        logic [1:0]              status;
        logic [POS_W-1:0]        position;
        logic [LEN_W-1:0]        length;
    } group_t;

    // bit 6 set: not in the alphabet
    function automatic logic [6:0] map_char(input logic [7:0] c, input logic url);
        logic [6:0] r;
        r = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b0, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end else if (url && c == 8'h2D) begin
            r = 7'd62;
        end else if (url && c == 8'h5F) begin
            r = 7'd63;
        end else if (!url && c == 8'h2B) begin
            r = 7'd62;
        end else if (!url && c == 8'h2F) begin
            r = 7'd63;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/b64d_step.sv @@
module b64d_step #(
    parameter int COUNT_WIDTH = 16
) (
    input  b64d_pkg::cfg_t        cfg,
    input  b64d_pkg::run_state_t  st,
    input  logic [COUNT_WIDTH-1:0] cpos,
    input  logic [COUNT_WIDTH-1:0] ocnt,
    input  logic [COUNT_WIDTH-1:0] fpos,
    input  logic                  has_char,
    input  logic [7:0]            ch,
    input  logic                  last,
    output b64d_pkg::run_state_t  st_next,
    output logic [COUNT_WIDTH-1:0] cpos_next,
    output logic [COUNT_WIDTH-1:0] ocnt_next,
    output logic [COUNT_WIDTH-1:0] fpos_next,
    output b64d_pkg::group_t      grp
);
    import b64d_pkg::*;

    logic [6:0]             sx;
    phase_t                 p;
    logic [17:0]            b;
    logic [1:0]             bc;
    logic [1:0]             pl;
    logic [1:0]             fs;
    logic [1:0]             nb;
    logic [1:0]             pad;
    logic [7:0]             by0;
    logic [7:0]             by1;
    logic [7:0]             by2;
    logic [COUNT_WIDTH-1:0] cp;
    logic [COUNT_WIDTH-1:0] fp;
    logic [COUNT_WIDTH-1:0] oc;
    logic [COUNT_WIDTH:0]   osum;
    logic                   char_used;

    assign sx = map_char(ch, cfg.url_alphabet);

    // walk of one item: data character, run close, pad/trailing, end of string
    always_comb begin
        p = st.phase;
        b = st.sextets;
        bc = st.bcount;
        pl = st.pads_left;
        fs = st.fstatus;
        cp = cpos;
        fp = fpos;
        nb = 2'd0;
        pad = 2'd0;
        by0 = 8'h00;
        by1 = 8'h00;
        by2 = 8'h00;
        char_used = 1'b0;

        if (has_char && p == PH_COLLECT && !sx[6]) begin
            char_used = 1'b1;
            cp = (&cp) ? cp : cp + COUNT_WIDTH'(1);
            if (bc == 2'd3) begin
                by0 = b[17:10];
                by1 = b[9:2];
                by2 = {b[1:0], sx[5:0]};
                nb = 2'd3;
                b = '0;
                bc = 2'd0;
            end else begin
                b = {b[11:0], sx[5:0]};
                bc = bc + 2'd1;
            end
        end

        // close of the data run; bytes from here always land in slots 0 and 1
        if (p == PH_COLLECT && ((has_char && sx[6]) || last)) begin
            if (bc == 2'd1) begin
                fs = ST_FORMAT;
                fp = cp;
                p = PH_DECIDED;
            end else begin
                if (bc == 2'd2) begin
                    by0 = b[11:4];
                    nb = 2'd1;
                    pad = 2'd2;
                end else if (bc == 2'd3) begin
                    by0 = b[17:10];
                    by1 = b[9:2];
                    nb = 2'd2;
                    pad = 2'd1;
                end
                b = '0;
                bc = 2'd0;
                if (cfg.pad_required && pad != 2'd0) begin
                    pl = pad;
                    p = PH_PAD;
                end else begin
                    pl = 2'd0;
                    p = PH_AFTER;
                end
            end
        end

        if (has_char && !char_used) begin
            if (p == PH_PAD) begin
                if (ch == PAD_CHAR) begin
                    cp = (&cp) ? cp : cp + COUNT_WIDTH'(1);
                    pl = pl - 2'd1;
                    if (pl == 2'd0) begin
                        p = PH_AFTER;
                    end
                end else begin
                    fs = ST_FORMAT;
                    fp = cp;
                    p = PH_DECIDED;
                end
            end else if (p == PH_AFTER && cfg.trail_check) begin
                fs = ST_TRAILING;
                fp = cp;
                p = PH_DECIDED;
            end
        end

        if (last) begin
            if (p == PH_PAD) begin
                fs = ST_FORMAT;
                fp = cp;
                p = PH_DECIDED;
            end else if (p == PH_AFTER) begin
                fs = ST_OK;
                fp = cp;
                p = PH_DECIDED;
            end
        end

        // saturating byte count
        osum = {1'b0, ocnt} + (COUNT_WIDTH + 1)'(nb);
        oc = osum[COUNT_WIDTH] ? '1 : osum[COUNT_WIDTH-1:0];
    end

    // next state; the end of a string returns the run to reset
    always_comb begin
        if (last) begin
            st_next = '0;
            cpos_next = '0;
            ocnt_next = '0;
            fpos_next = '0;
        end else begin
            st_next.phase = p;
            st_next.sextets = b;
            st_next.bcount = bc;
            st_next.pads_left = pl;
            st_next.fstatus = fs;
            cpos_next = cp;
            ocnt_next = oc;
            fpos_next = fp;
        end
    end

    // results of this item
    always_comb begin
        grp.nbytes = nb;
        grp.bytes[0] = by0;
        grp.bytes[1] = by1;
        grp.bytes[2] = by2;
        grp.has_status = last;
        grp.status = fs;
        grp.position = POS_W'(fp);
        grp.length = LEN_W'(oc);
    end

endmodule

@@ rtl/core/b64d_queue.sv @@
`include "base64_stream_decoder_unit_assert.svh"

module b64d_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  b64d_pkg::group_t  grp_in,
    output logic              q_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_is_status,
    output logic [7:0]        m_data_byte,
    output logic [1:0]        m_status,
    output logic [15:0]       m_position,
    output logic [15:0]       m_decoded_length,
    output logic              m_run_end
);
    import b64d_pkg::*;

    group_t              slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_CNT_W-1:0]  count_reg;
    logic [Q_CNT_W-1:0]  count_next;
    logic [1:0]          sub_reg;
    logic [1:0]          last_idx;
    logic [7:0]          sel_byte;
    logic                pop;
    logic                out_fire;
    group_t              head;

    assign head = slot_reg[rd_ptr_reg];
    assign q_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign m_valid = (count_reg != '0);
    assign out_fire = m_valid && m_ready;
    assign pop = out_fire && m_run_end;

    // serializer over the head group: bytes first, status last
    always_comb begin
        last_idx = head.has_status ? head.nbytes : head.nbytes - 2'd1;
        unique case (sub_reg)
            2'd0: sel_byte = head.bytes[0];
            2'd1: sel_byte = head.bytes[1];
            2'd2: sel_byte = head.bytes[2];
            2'd3: sel_byte = 8'h00;
        endcase
        m_is_status = head.has_status && (sub_reg == head.nbytes);
        m_data_byte = m_is_status ? 8'h00 : sel_byte;
        m_status = m_is_status ? head.status : ST_OK;
        m_position = m_is_status ? head.position : '0;
        m_decoded_length = m_is_status ? head.length : '0;
        m_run_end = (sub_reg == last_idx);
    end

    always_comb begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + Q_CNT_W'(1);
            2'b01:   count_next = count_reg - Q_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= grp_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
            sub_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (out_fire) begin
                sub_reg <= m_run_end ? 2'd0 : sub_reg + 2'd1;
            end
        end
    end

    `B64D_ASSERT(a_no_overflow, aclk, aresetn, !(push && (count_reg == Q_CNT_W'(Q_DEPTH))))
    `B64D_ASSERT(a_count_range, aclk, aresetn, count_reg <= Q_CNT_W'(Q_DEPTH))
    `B64D_ASSERT(a_sub_range, aclk, aresetn, (count_reg != '0) |-> (sub_reg <= last_idx))
    `B64D_ASSERT_RST(a_empty_after_reset, aclk, (!aresetn) |=> (count_reg == '0))

endmodule

@@ rtl/core/base64_stream_decoder_unit.sv @@
// Base64 stream decoder (standard or URL-safe alphabet).
// Input channel s_*: one character per transaction (s_has_char, s_character),
// s_last closes the string; an item with s_has_char low and s_last high ends
// the string without a character. Result channel m_*: one decoded byte per
// transaction, and after the string's last item one status transaction
// (m_is_status high) with the error code, the error offset or consumed count,
// and the byte count. m_run_end marks the last result caused by one input item.
// Config port cfg_*: a one-cycle write of one bit to register cfg_index
// (0 alphabet select, 1 expect padding, 2 trailing check); write it while idle.
// Path: an accepted item is decoded from the input register once the queue
// has room; its result group enters the queue and m_* shows the queue head.
// Throughput: one input item per cycle as long as results drain; the result
// side moves one transaction per cycle while m_ready is high, so a character
// that completes a quantum (three bytes) gives three transactions. A four-entry
// queue of per-item result groups sits between the decode step and m_*.
// Stall: when m_ready is low the queue fills, then the input register holds
// its item and s_ready drops; nothing is dropped or repeated.
// Reset: aresetn (synchronous, active low) empties the queue and input
// register, clears the run state and loads the register defaults.
`include "base64_stream_decoder_unit_assert.svh"

module base64_stream_decoder_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_has_char,
    input  logic [7:0]  s_character,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_status,
    output logic [7:0]  m_data_byte,
    output logic [1:0]  m_status,
    output logic [15:0] m_position,
    output logic [15:0] m_decoded_length,
    output logic        m_run_end
);
    import b64d_pkg::*;

    // configuration registers
    cfg_t cfg_reg;

    // input register stage
    logic       in_valid_reg;
    logic       has_char_reg;
    logic [7:0] char_reg;
    logic       last_reg;

    // run state
    run_state_t             run_reg;
    run_state_t             run_next;
    logic [COUNT_WIDTH-1:0] cpos_reg;
    logic [COUNT_WIDTH-1:0] cpos_next;
    logic [COUNT_WIDTH-1:0] ocnt_reg;
    logic [COUNT_WIDTH-1:0] ocnt_next;
    logic [COUNT_WIDTH-1:0] fpos_reg;
    logic [COUNT_WIDTH-1:0] fpos_next;

    group_t grp;
    logic   q_ready;
    logic   step_fire;
    logic   in_fire;
    logic   push;

    // the held item is decoded once the queue can take its result group
    assign step_fire = in_valid_reg && q_ready;
    assign s_ready = !in_valid_reg || step_fire;
    assign in_fire = s_valid && s_ready;
    // items that cause no result (buffered or ignored characters) leave no group behind
    assign push = step_fire && (grp.has_status || grp.nbytes != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.url_alphabet <= 1'b0;
            cfg_reg.pad_required <= 1'b1;
            cfg_reg.trail_check <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_URL_ALPHABET: cfg_reg.url_alphabet <= cfg_wdata;
                CFG_PAD_REQUIRED: cfg_reg.pad_required <= cfg_wdata;
                CFG_TRAIL_CHECK:  cfg_reg.trail_check <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            has_char_reg <= s_has_char;
            char_reg <= s_character;
            last_reg <= s_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            run_reg <= '0;
            cpos_reg <= '0;
            ocnt_reg <= '0;
            fpos_reg <= '0;
        end else begin
            if (in_fire) begin
                in_valid_reg <= 1'b1;
            end else if (step_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (step_fire) begin
                run_reg <= run_next;
                cpos_reg <= cpos_next;
                ocnt_reg <= ocnt_next;
                fpos_reg <= fpos_next;
            end
        end
    end

    b64d_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .cfg       (cfg_reg),
        .st        (run_reg),
        .cpos      (cpos_reg),
        .ocnt      (ocnt_reg),
        .fpos      (fpos_reg),
        .has_char  (has_char_reg),
        .ch        (char_reg),
        .last      (last_reg),
        .st_next   (run_next),
        .cpos_next (cpos_next),
        .ocnt_next (ocnt_next),
        .fpos_next (fpos_next),
        .grp       (grp)
    );

    b64d_queue u_queue (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .push             (push),
        .grp_in           (grp),
        .q_ready          (q_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_status      (m_is_status),
        .m_data_byte      (m_data_byte),
        .m_status         (m_status),
        .m_position       (m_position),
        .m_decoded_length (m_decoded_length),
        .m_run_end        (m_run_end)
    );

    // end of string leaves a fresh run behind
    `B64D_ASSERT(a_last_clears, aclk, aresetn,
        (step_fire && last_reg) |=> ((run_reg.phase == PH_COLLECT) && (cpos_reg == '0)
            && (ocnt_reg == '0)))
    // a held item stays put until decoded
    `B64D_ASSERT(a_hold_item, aclk, aresetn,
        (in_valid_reg && !step_fire) |=> (in_valid_reg && $stable({char_reg, last_reg})))
    // the last item of a string always leaves a status group
    `B64D_ASSERT(a_last_pushes, aclk, aresetn,
        (step_fire && last_reg) |-> (push && grp.has_status))

endmodule
